// ===== sv/ptam_pkg.sv =====
// ----------------------------------------------------------------------------
// ptam_pkg
// Shared types and constants for the peer table activation manager.
// ----------------------------------------------------------------------------
`default_nettype none

package ptam_pkg;

    localparam int MAX_PEERS_DEF = 20;
    localparam int MAC_W         = 48;
    localparam int TIMEOUT_W     = 16;
    localparam int LIMIT_W       = 4;
    localparam int PEN_W         = 3;
    localparam int CFG_IDX_W     = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd2000;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 4'd5;
    localparam logic [PEN_W-1:0]     PEN_RST     = 3'd2;
    localparam logic [LIMIT_W-1:0]   FC_MAX      = 4'd15;

    typedef enum logic [2:0] {
        REQ_REGISTER = 3'd0,
        REQ_SEND     = 3'd1,
        REQ_REPORT   = 3'd2,
        REQ_ACK      = 3'd3,
        REQ_SELECT   = 3'd4,
        REQ_TICK     = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        KIND_STATUS   = 3'd0,
        KIND_ACK      = 3'd1,
        KIND_ACTIVATE = 3'd2,
        KIND_DEACT    = 3'd3,
        KIND_ADDED    = 3'd4,
        KIND_REMOVED  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_LIMIT   = 2'd1,
        CFG_PENALTY = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_ADD,
        S_ACKOUT,
        S_HIT,
        S_RM_A,
        S_RM_B,
        S_RM_C,
        S_SN,
        S_SN_DEACT,
        S_SN_RDN,
        S_SN_ACT,
        S_ACK_CMP,
        S_STATUS
    } t_state;

endpackage

`default_nettype wire

// ===== sv/ptam_ram.sv =====
// ----------------------------------------------------------------------------
// ptam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptam_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 20
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/peer_table_activation_manager_top.sv =====
// ----------------------------------------------------------------------------
// peer_table_activation_manager_top
// Compact peer table with failure counting, round-robin activation handshake
// and activate timeout; one shared address compare under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_stall      req_type, peer_mac, flags
//  out       source     o_out_valid / i_out_stall    kind, mac, state snapshot
//  cfg       sink       i_cfg_valid / o_cfg_ready    index, data
//
//  an item is accepted, then the N entries are searched (read, compare next
//  cycle); then come the flag update, a removal (read the entry, read the last,
//  move), a select-next (deactivate, read, activate) and the status item
//  the addresses sit in a single-port-read ram; the one read port sets the pace
//  reset is synchronous, active low, and clears the table at once (no sweep)
//  a stalled output holds the sequencer in its emitting state
// ----------------------------------------------------------------------------
`default_nettype none

module peer_table_activation_manager_top #(
    parameter int MAX_PEERS = ptam_pkg::MAX_PEERS_DEF,
    parameter int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
    parameter int CW = $clog2(MAX_PEERS + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input items
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [2:0]                      i_req_type,
    input  wire logic [ptam_pkg::MAC_W-1:0]      i_peer_mac,
    input  wire logic                            i_heartbeat_send,
    input  wire logic                            i_immediate_fail,
    input  wire logic                            i_delivered,
    // result items
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [2:0]                           o_out_kind,
    output logic [ptam_pkg::MAC_W-1:0]           o_out_mac,
    output logic [CW-1:0]                        o_peer_count,
    output logic                                 o_active_valid,
    output logic [IW-1:0]                        o_active_index,
    output logic                                 o_waiting_ack,
    output logic                                 o_last,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ptam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ptam_pkg::TIMEOUT_W-1:0]  i_cfg_data
);

    import ptam_pkg::*;

    // configuration registers
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [LIMIT_W-1:0]   r_limit;
    logic [PEN_W-1:0]     r_pen;

    // sequencer and captured item
    t_state r_state, n_state;
    t_req   r_origin, n_origin;
    logic [MAC_W-1:0] r_mac, n_mac;
    logic r_hbin, n_hbin, r_imm, n_imm, r_ok, n_ok;
    logic [CW-1:0] r_i, n_i;
    logic r_pv, n_pv;
    logic [IW-1:0] r_pi, n_pi, r_slot, n_slot, r_next, n_next;
    logic [MAC_W-1:0] r_rmmac, n_rmmac;

    // table state
    logic [CW-1:0] r_count, n_count;
    logic r_act_v, n_act_v, r_await, n_await;
    logic [IW-1:0] r_act, n_act, r_pend, n_pend;
    logic [TIMEOUT_W-1:0] r_age, n_age;
    logic [LIMIT_W-1:0] r_fc [MAX_PEERS];
    logic [LIMIT_W-1:0] n_fc [MAX_PEERS];
    logic r_hb [MAX_PEERS];
    logic n_hb [MAX_PEERS];
    logic r_sup [MAX_PEERS];
    logic n_sup [MAX_PEERS];

    // output register
    logic r_ov;
    logic [2:0] r_okind;
    logic [MAC_W-1:0] r_omac;
    logic [CW-1:0] r_ocnt;
    logic r_oav, r_owa, r_olast;
    logic [IW-1:0] r_oai;

    // address ram
    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [MAC_W-1:0] ram_wdata, ram_rdata;

    ptam_ram #(.WIDTH(MAC_W), .DEPTH(MAX_PEERS)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // emit controls
    logic e_do, e_last, out_free, in_acc;
    t_kind e_kind;
    logic [MAC_W-1:0] e_mac;

    // per-entry flag read, one address at a time
    logic [IW-1:0] f_addr, last_idx;
    logic [LIMIT_W-1:0] f_fc, new_fc, inc;
    logic f_hb, f_sup, hitp, act_keep, mac_hit;
    logic [LIMIT_W:0] fc_sum;

    assign out_free    = !r_ov || !i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign last_idx    = IW'(r_count - CW'(1));
    assign mac_hit     = r_pv && (ram_rdata == r_mac);

    assign f_fc  = r_fc[f_addr];
    assign f_hb  = r_hb[f_addr];
    assign f_sup = r_sup[f_addr];

    // the shared saturating adder for failure counts
    assign fc_sum = {1'b0, f_fc} + {1'b0, inc};
    assign new_fc = (fc_sum > {1'b0, FC_MAX}) ? FC_MAX : fc_sum[LIMIT_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_origin = r_origin;
        n_mac    = r_mac;
        n_hbin   = r_hbin;
        n_imm    = r_imm;
        n_ok     = r_ok;
        n_i      = r_i;
        n_pv     = r_pv;
        n_pi     = r_pi;
        n_slot   = r_slot;
        n_next   = r_next;
        n_rmmac  = r_rmmac;
        n_count  = r_count;
        n_act_v  = r_act_v;
        n_act    = r_act;
        n_await  = r_await;
        n_pend   = r_pend;
        n_age    = r_age;
        n_fc     = r_fc;
        n_hb     = r_hb;
        n_sup    = r_sup;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = ram_rdata;
        ram_raddr = r_pend;
        f_addr    = r_slot;
        inc       = LIMIT_W'(r_pen);
        hitp      = 1'b0;
        act_keep  = 1'b0;
        e_do   = 1'b0;
        e_last = 1'b1;
        e_kind = KIND_STATUS;
        e_mac  = r_mac;

        unique case (r_state)
            S_IDLE: begin
                // ram read of the pending entry is issued here for activate ack
                ram_raddr = r_pend;
                if (in_acc) begin
                    n_origin = t_req'(i_req_type);
                    n_mac    = i_peer_mac;
                    n_hbin   = i_heartbeat_send;
                    n_imm    = i_immediate_fail;
                    n_ok     = i_delivered;
                    n_i      = '0;
                    n_pv     = 1'b0;
                    case (i_req_type)
                        REQ_REGISTER, REQ_SEND, REQ_REPORT: n_state = S_SEARCH;
                        REQ_ACK: begin
                            if (r_await && ({1'b0, r_pend} < (CW+1)'(r_count)))
                                n_state = S_ACK_CMP;
                            else
                                n_state = S_STATUS;
                        end
                        REQ_SELECT: n_state = S_SN;
                        REQ_TICK: begin
                            n_state = S_STATUS;
                            if (r_await) begin
                                if (r_age >= r_timeout) begin
                                    // timeout: handshake dropped before the removal
                                    n_await = 1'b0;
                                    n_age   = '0;
                                    if ({1'b0, r_pend} < (CW+1)'(r_count)) begin
                                        n_slot  = r_pend;
                                        n_state = S_RM_A;
                                    end
                                end else begin
                                    n_age = r_age + TIMEOUT_W'(1);
                                end
                            end
                        end
                        default: n_state = S_STATUS;
                    endcase
                end
            end

            S_SEARCH: begin
                // issue one read per cycle, compare the previous one
                ram_raddr = r_i[IW-1:0];
                if (mac_hit) begin
                    n_pv   = 1'b0;
                    n_slot = r_pi;
                    n_state = (r_origin == REQ_REGISTER) ? S_ACKOUT : S_HIT;
                end else if (r_i < r_count) begin
                    n_pv = 1'b1;
                    n_pi = r_i[IW-1:0];
                    n_i  = r_i + CW'(1);
                end else begin
                    n_pv = 1'b0;
                    if (r_origin == REQ_REGISTER)
                        n_state = (r_count < CW'(MAX_PEERS)) ? S_ADD : S_ACKOUT;
                    else
                        n_state = S_STATUS;
                end
            end

            S_ADD: begin
                if (out_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IW-1:0];
                    ram_wdata = r_mac;
                    n_fc[r_count[IW-1:0]]  = '0;
                    n_hb[r_count[IW-1:0]]  = 1'b0;
                    n_sup[r_count[IW-1:0]] = 1'b0;
                    n_count = r_count + CW'(1);
                    e_do    = 1'b1;
                    e_kind  = KIND_ADDED;
                    e_last  = 1'b0;
                    n_state = S_ACKOUT;
                end
            end

            S_ACKOUT: begin
                if (out_free) begin
                    e_do    = 1'b1;
                    e_kind  = KIND_ACK;
                    n_state = S_IDLE;
                end
            end

            S_HIT: begin
                f_addr  = r_slot;
                n_state = S_STATUS;
                if (r_origin == REQ_SEND) begin
                    n_hb[r_slot] = r_hbin;
                    if (r_imm && r_hbin) begin
                        inc = LIMIT_W'(r_pen);
                        n_fc[r_slot]  = new_fc;
                        n_sup[r_slot] = 1'b1;
                        if (new_fc >= r_limit)
                            n_state = S_RM_A;
                    end
                end else begin
                    if (r_ok) begin
                        n_fc[r_slot]  = '0;
                        n_hb[r_slot]  = 1'b0;
                        n_sup[r_slot] = 1'b0;
                    end else if (f_sup) begin
                        n_sup[r_slot] = 1'b0;
                        n_hb[r_slot]  = 1'b0;
                    end else begin
                        inc = f_hb ? LIMIT_W'(r_pen) : LIMIT_W'(1);
                        n_fc[r_slot] = new_fc;
                        n_hb[r_slot] = 1'b0;
                        if (new_fc >= r_limit)
                            n_state = S_RM_A;
                    end
                end
            end

            S_RM_A: begin
                ram_raddr = r_slot;
                n_state   = S_RM_B;
            end

            S_RM_B: begin
                n_rmmac   = ram_rdata;
                ram_raddr = last_idx;
                n_state   = S_RM_C;
            end

            S_RM_C: begin
                // last entry moves into the gap
                ram_raddr = last_idx;
                f_addr    = last_idx;
                hitp      = r_await && (r_pend == r_slot);
                act_keep  = r_act_v && (r_act != r_slot);
                if (out_free) begin
                    if (r_slot != last_idx) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_slot;
                        ram_wdata = ram_rdata;
                        n_fc[r_slot]  = f_fc;
                        n_hb[r_slot]  = f_hb;
                        n_sup[r_slot] = f_sup;
                        if (act_keep && (r_act == last_idx))
                            n_act = r_slot;
                        if (!hitp && (r_pend == last_idx))
                            n_pend = r_slot;
                    end
                    n_fc[last_idx]  = '0;
                    n_hb[last_idx]  = 1'b0;
                    n_sup[last_idx] = 1'b0;
                    n_count = r_count - CW'(1);
                    n_act_v = act_keep;
                    if (hitp) begin
                        n_await = 1'b0;
                        n_pend  = '0;
                    end
                    e_do   = 1'b1;
                    e_kind = KIND_REMOVED;
                    e_mac  = r_rmmac;
                    if ((r_origin == REQ_SEND) && (n_count != '0)) begin
                        e_last  = n_await;
                        n_state = S_SN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_SN: begin
                ram_raddr = r_act;
                if ((r_count == '0) || r_await) begin
                    n_state = (r_origin == REQ_SELECT) ? S_STATUS : S_IDLE;
                end else begin
                    if (r_act_v)
                        n_next = ((CW'(r_act) + CW'(1)) == r_count) ? '0 : r_act + IW'(1);
                    else
                        n_next = '0;
                    n_state = r_act_v ? S_SN_DEACT : S_SN_RDN;
                end
            end

            S_SN_DEACT: begin
                ram_raddr = r_act;
                if (out_free) begin
                    n_act_v = 1'b0;
                    e_do    = 1'b1;
                    e_kind  = KIND_DEACT;
                    e_mac   = ram_rdata;
                    e_last  = 1'b0;
                    n_state = S_SN_RDN;
                end
            end

            S_SN_RDN: begin
                ram_raddr = r_next;
                n_state   = S_SN_ACT;
            end

            S_SN_ACT: begin
                ram_raddr = r_next;
                if (out_free) begin
                    n_hb[r_next] = 1'b0;
                    n_await = 1'b1;
                    n_age   = '0;
                    n_pend  = r_next;
                    e_do    = 1'b1;
                    e_kind  = KIND_ACTIVATE;
                    e_mac   = ram_rdata;
                    n_state = S_IDLE;
                end
            end

            S_ACK_CMP: begin
                ram_raddr = r_pend;
                if (ram_rdata == r_mac) begin
                    n_act   = r_pend;
                    n_act_v = 1'b1;
                    n_await = 1'b0;
                end
                n_state = S_STATUS;
            end

            S_STATUS: begin
                if (out_free) begin
                    e_do    = 1'b1;
                    e_kind  = KIND_STATUS;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_count <= '0;
            r_act_v <= 1'b0;
            r_act   <= '0;
            r_await <= 1'b0;
            r_pend  <= '0;
            r_age   <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < MAX_PEERS; k++) begin
                r_fc[k]  <= '0;
                r_hb[k]  <= 1'b0;
                r_sup[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_count <= n_count;
            r_act_v <= n_act_v;
            r_act   <= n_act;
            r_await <= n_await;
            r_pend  <= n_pend;
            r_age   <= n_age;
            r_fc    <= n_fc;
            r_hb    <= n_hb;
            r_sup   <= n_sup;
            if (e_do)
                r_ov <= 1'b1;
            else if (!i_out_stall)
                r_ov <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_limit   <= LIMIT_RST;
            r_pen     <= PEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_W-1:0];
                CFG_PENALTY: r_pen     <= i_cfg_data[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_origin <= n_origin;
        r_mac    <= n_mac;
        r_hbin   <= n_hbin;
        r_imm    <= n_imm;
        r_ok     <= n_ok;
        r_i      <= n_i;
        r_pi     <= n_pi;
        r_slot   <= n_slot;
        r_next   <= n_next;
        r_rmmac  <= n_rmmac;
        if (e_do) begin
            // snapshot of the table state just after the action
            r_okind <= e_kind;
            r_omac  <= e_mac;
            r_ocnt  <= n_count;
            r_oav   <= n_act_v;
            r_oai   <= n_act;
            r_owa   <= n_await;
            r_olast <= e_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_kind     = r_okind;
    assign o_out_mac      = r_omac;
    assign o_peer_count   = r_ocnt;
    assign o_active_valid = r_oav;
    assign o_active_index = r_oai;
    assign o_waiting_ack  = r_owa;
    assign o_last         = r_olast;

`ifndef SYNTH
    // a pending handshake always points inside the table
    a_pend_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> ({1'b0, r_pend} < (CW+1)'(r_count)))
        else $error("pending index outside table");

    // the active peer always points inside the table
    a_act_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_v |-> ({1'b0, r_act} < (CW+1)'(r_count)))
        else $error("active index outside table");

    // table never overfills
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PEERS))
        else $error("entry count above capacity");

    // a new result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |-> !e_do)
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire
